>>> rtl/core/rlfe_pkg.sv
`default_nettype none
package rlfe_pkg;

  localparam int CHANNELS_DEF  = 3;
  localparam int FRAC_BITS_DEF = 8;
  localparam int TARGET_W      = 8;
  localparam int TIME_W        = 12;
  localparam int PWM_W         = 10;
  // sixteen ticks per time unit
  localparam int TICK_SHIFT    = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_DIV,
    S_TICK,
    S_FINISH
  } fade_state_t;

endpackage
`default_nettype wire

>>> rtl/core/rlfe_div.sv
`default_nettype none
module rlfe_div import rlfe_pkg::*; #(
  parameter int DW = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DW-1:0]     dividend,
  input  wire logic [TIME_W-1:0] divisor,
  output logic                   done,
  output logic [DW-1:0]          quotient
);

  localparam int CNTW = $clog2(DW);

  logic [TIME_W-1:0] rem;
  logic [DW-1:0]     quot;
  logic [CNTW-1:0]   cnt;
  logic              running;

  logic [TIME_W:0] trial;
  logic [TIME_W:0] diff;
  logic            ge;

  // one quotient bit per cycle, dividend shifts out as quotient shifts in
  always_comb begin
    trial = {rem, quot[DW-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(DW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (running) begin
      quot <= {quot[DW-2:0], ge};
      rem  <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
    end
  end

  assign quotient = quot;

endmodule
`default_nettype wire

>>> rtl/core/rlfe_tick.sv
`default_nettype none
module rlfe_tick import rlfe_pkg::*; #(
  parameter int LW = 16
) (
  input  wire logic [LW-1:0]       level,
  input  wire logic signed [LW:0]  step,
  input  wire logic [LW-1:0]       end_level,
  input  wire logic                lamp_on,
  output logic [LW-1:0]            level_next,
  output logic                     moved
);

  // one channel moved by one step, clamped at its end point
  rlfe_step #(.LW(LW)) u_step (
    .level      (level),
    .step       (step),
    .end_level  (end_level),
    .lamp_on    (lamp_on),
    .level_next (level_next),
    .moved      (moved)
  );

endmodule
`default_nettype wire

>>> rtl/core/rlfe_step.sv
`default_nettype none
module rlfe_step import rlfe_pkg::*; #(
  parameter int LW = 16
) (
  input  wire logic [LW-1:0]      level,
  input  wire logic signed [LW:0] step,
  input  wire logic [LW-1:0]      end_level,
  input  wire logic               lamp_on,
  output logic [LW-1:0]           level_next,
  output logic                    moved
);

  logic signed [LW+1:0] vx;
  logic signed [LW+1:0] sx;
  logic signed [LW+1:0] ex;
  logic signed [LW+1:0] sum;
  logic signed [LW+1:0] lvl_max;

  always_comb begin
    vx      = $signed({2'b00, level});
    sx      = {step[LW], step};
    ex      = $signed({2'b00, end_level});
    lvl_max = $signed({2'b00, {LW{1'b1}}});
    moved   = (level != end_level);
    if (lamp_on) begin
      sum = vx + sx;
      // never run past the target
      if ((sx > 0 && sum > ex) || (sx < 0 && sum < ex)) begin
        sum = ex;
      end
    end else begin
      sum = vx - sx;
    end
    if (sum < 0) begin
      sum = '0;
    end else if (sum > lvl_max) begin
      sum = lvl_max;
    end
    level_next = moved ? sum[LW-1:0] : level;
  end

endmodule
`default_nettype wire

>>> rtl/core/rgb_linear_fade_engine_unit.sv
`default_nettype none
// channel | handshake              | payload
// --------+------------------------+-------------------------------------------
// in      | in_valid / in_stall    | mode, light_on, target_*, transition_time
// out     | out_valid / out_stall  | pwm_red, pwm_green, pwm_blue, in_transition
//
// tick: one channel per cycle through the step adder.
// command: channels in turn, paced by the bit-serial divider (one quotient
// bit per cycle); zero time skips the divider and jumps to the end points.
// one transaction is worked at a time; a new one is taken while the last
// result waits. synchronous reset clears levels, steps and goals.
// out_stall only holds the finishing result until the output register frees.
module rgb_linear_fade_engine_unit import rlfe_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                mode,
  input  wire logic                light_on,
  input  wire logic [TARGET_W-1:0] target_red,
  input  wire logic [TARGET_W-1:0] target_green,
  input  wire logic [TARGET_W-1:0] target_blue,
  input  wire logic [TIME_W-1:0]   transition_time,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [PWM_W-1:0]         pwm_red,
  output logic [PWM_W-1:0]         pwm_green,
  output logic [PWM_W-1:0]         pwm_blue,
  output logic                     in_transition
);

  localparam int LW = TARGET_W + FRAC_BITS;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  fade_state_t state, state_next;

  logic [LW-1:0]       level_now  [CHANNELS];
  logic signed [LW:0]  step_size  [CHANNELS];
  logic [TARGET_W-1:0] level_goal [CHANNELS];
  logic                lamp_on;

  logic [CW-1:0]       ch;
  logic [TARGET_W-1:0] tgt_r, tgt_g, tgt_b;
  logic [TIME_W-1:0]   t_units;
  logic                changed;

  logic                in_take;
  logic                out_load;
  logic                last_ch;
  logic                div_start;
  logic                div_done;
  logic [LW-1:0]       div_quot;

  logic [TARGET_W-1:0] goal_sel;
  logic [LW-1:0]       end_cmd;
  logic [LW-1:0]       end_tick;
  logic signed [LW:0]  delta;
  logic [LW-1:0]       mag;
  logic                neg;
  logic [LW-1:0]       q;
  logic signed [LW:0]  step_new;
  logic [LW-1:0]       tick_level;
  logic                tick_moved;

  assign in_take = in_valid && !in_stall;
  assign last_ch = (ch == CW'(CHANNELS - 1));

  // channels past the third take target zero
  always_comb begin
    priority case (ch)
      CW'(0):  goal_sel = tgt_r;
      CW'(1):  goal_sel = (CHANNELS > 1) ? tgt_g : '0;
      CW'(2):  goal_sel = (CHANNELS > 2) ? tgt_b : '0;
      default: goal_sel = '0;
    endcase
  end

  always_comb begin
    end_cmd  = lamp_on ? {goal_sel, {FRAC_BITS{1'b0}}} : '0;
    end_tick = lamp_on ? {level_goal[ch], {FRAC_BITS{1'b0}}} : '0;
    delta    = $signed({1'b0, end_cmd}) - $signed({1'b0, level_now[ch]});
    neg      = lamp_on && delta[LW];
    if (!lamp_on) begin
      mag = level_now[ch];
    end else if (neg) begin
      mag = LW'(-delta);
    end else begin
      mag = delta[LW-1:0];
    end
    q = div_quot >> TICK_SHIFT;
    // a fade always finishes: at least one lsb per tick
    if (q == '0 && mag != '0) begin
      q = LW'(1);
    end
    step_new = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  rlfe_div #(.DW(LW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (t_units),
    .done     (div_done),
    .quotient (div_quot)
  );

  rlfe_tick #(.LW(LW)) u_tick (
    .level      (level_now[ch]),
    .step       (step_size[ch]),
    .end_level  (end_tick),
    .lamp_on    (lamp_on),
    .level_next (tick_level),
    .moved      (tick_moved)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take) state_next = mode ? S_CMD : S_TICK;
      end
      S_CMD: begin
        if (t_units != '0) state_next = S_DIV;
        else if (last_ch)  state_next = S_FINISH;
      end
      S_DIV: begin
        if (div_done) state_next = last_ch ? S_FINISH : S_CMD;
      end
      S_TICK: begin
        if (last_ch) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    div_start = (state == S_CMD) && (t_units != '0);
    out_load  = (state == S_FINISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_on <= 1'b0;
      ch      <= '0;
      changed <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        level_now[c]  <= '0;
        step_size[c]  <= '0;
        level_goal[c] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          ch      <= '0;
          changed <= 1'b0;
          if (in_take && mode) lamp_on <= light_on;
        end
        S_CMD: begin
          level_goal[ch] <= goal_sel;
          if (t_units == '0) begin
            // zero time: jump straight to the end point
            if (level_now[ch] != end_cmd) changed <= 1'b1;
            level_now[ch] <= end_cmd;
            step_size[ch] <= '0;
            ch <= ch + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            step_size[ch] <= step_new;
            ch <= ch + 1'b1;
          end
        end
        S_TICK: begin
          level_now[ch] <= tick_level;
          if (tick_moved) changed <= 1'b1;
          ch <= ch + 1'b1;
        end
        S_FINISH: begin
          ch <= '0;
        end
        default: begin
          ch <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && mode) begin
      tgt_r   <= target_red;
      tgt_g   <= target_green;
      tgt_b   <= target_blue;
      t_units <= transition_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  logic [PWM_W-1:0] pwm_ch [3];

  for (genvar g = 0; g < 3; g++) begin : g_pwm
    if (g < CHANNELS) begin : g_on
      assign pwm_ch[g] = level_now[g][LW-1:FRAC_BITS-2];
    end else begin : g_off
      assign pwm_ch[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pwm_red       <= pwm_ch[0];
      pwm_green     <= pwm_ch[1];
      pwm_blue      <= pwm_ch[2];
      in_transition <= changed;
    end
  end

endmodule
`default_nettype wire
